### rtl/mbsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbsc_pkg
// Shared types, register indices and helpers for the MSB-first bit stream
// concatenation block.
// ----------------------------------------------------------------------------
package mbsc_pkg;

    localparam int CFG_INDEX_WIDTH  = 2;
    localparam int FIFO_DEPTH       = 4;
    localparam int FIFO_PTR_WIDTH   = 2;
    localparam int FIFO_LEVEL_WIDTH = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FIRST_LENGTH  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SECOND_LENGTH = 2'd1;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic [FIFO_LEVEL_WIDTH-1:0] level;
        logic                        room;
    } fifo_status_t;

    function automatic logic [7:0] top_bits_mask(input logic [3:0] n);
        return ~(8'hFF >> n);
    endfunction

endpackage
`default_nettype wire

### rtl/mbsc_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbsc_core
// Per-byte merge stage: masks the incoming byte to its valid bits, merges it
// with the held partial byte and produces up to two result bytes.
// ----------------------------------------------------------------------------
module mbsc_core import mbsc_pkg::*; #(
    parameter int LENGTH_WIDTH = 24
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    step,
    input  wire logic [7:0]              data_byte,
    input  wire logic [LENGTH_WIDTH-1:0] first_len,
    input  wire logic [LENGTH_WIDTH-1:0] second_len,
    input  wire logic [LENGTH_WIDTH-3:0] first_bytes,
    input  wire logic [LENGTH_WIDTH-3:0] second_bytes,
    output push_t                        push
);

    localparam int CW = LENGTH_WIDTH - 2;
    localparam int NW = LENGTH_WIDTH - 1;

    logic [7:0]    pend_byte_reg, pend_byte_next;
    logic [2:0]    pend_cnt_reg, pend_cnt_next;
    logic [CW-1:0] taken_reg, taken_next;

    logic [NW-1:0] total_bytes;
    logic [NW-1:0] idx_inc;
    logic          empty_job;
    logic          last;
    logic [3:0]    nbits;
    logic [7:0]    valid_bits;
    logic [7:0]    merged;
    logic [7:0]    spill;
    logic [3:0]    sum;
    logic          emit;
    logic          emit_last;
    logic [7:0]    new_byte;
    logic [2:0]    new_cnt;
    logic          tail;

    always_comb begin
        total_bytes = {1'b0, first_bytes} + {1'b0, second_bytes};
        idx_inc     = {1'b0, taken_reg} + NW'(1);
        empty_job   = (first_len == '0) && (second_len == '0);
        last        = idx_inc >= total_bytes;

        if (taken_reg < first_bytes) begin
            nbits = (idx_inc == {1'b0, first_bytes} && first_len[2:0] != 3'd0)
                    ? {1'b0, first_len[2:0]} : 4'd8;
        end else if (second_bytes == '0) begin
            nbits = 4'd0;
        end else begin
            nbits = (last && second_len[2:0] != 3'd0)
                    ? {1'b0, second_len[2:0]} : 4'd8;
        end

        valid_bits = data_byte & top_bits_mask(nbits);
        merged     = pend_byte_reg | (valid_bits >> pend_cnt_reg);
        spill      = 8'({valid_bits, 8'h00} >> pend_cnt_reg);
        sum        = {1'b0, pend_cnt_reg} + nbits;

        if (sum >= 4'd8) begin
            emit      = 1'b1;
            emit_last = last && (sum == 4'd8);
            new_byte  = spill;
            new_cnt   = 3'(sum - 4'd8);
        end else begin
            emit      = 1'b0;
            emit_last = 1'b0;
            new_byte  = merged;
            new_cnt   = sum[2:0];
        end

        tail = last && (new_cnt != 3'd0);

        push.second.out_byte = new_byte;
        push.second.is_last  = 1'b1;
        if (emit) begin
            push.first.out_byte = merged;
            push.first.is_last  = emit_last;
        end else begin
            push.first.out_byte = new_byte;
            push.first.is_last  = 1'b1;
        end

        if (!step || empty_job) begin
            push.count = 2'd0;
        end else begin
            push.count = {1'b0, emit} + {1'b0, tail};
        end

        pend_byte_next = pend_byte_reg;
        pend_cnt_next  = pend_cnt_reg;
        taken_next     = taken_reg;
        if (step) begin
            if (empty_job || last) begin
                pend_byte_next = '0;
                pend_cnt_next  = '0;
                taken_next     = '0;
            end else begin
                pend_byte_next = new_byte;
                pend_cnt_next  = new_cnt;
                taken_next     = idx_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_byte_reg <= '0;
            pend_cnt_reg  <= '0;
            taken_reg     <= '0;
        end else begin
            pend_byte_reg <= pend_byte_next;
            pend_cnt_reg  <= pend_cnt_next;
            taken_reg     <= taken_next;
        end
    end

endmodule
`default_nettype wire

### rtl/mbsc_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbsc_out_fifo
// Small result queue that takes up to two result bytes per cycle and hands
// out one per transfer.
// ----------------------------------------------------------------------------
module mbsc_out_fifo import mbsc_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire push_t push,
    input  wire logic  pop,
    output result_t    head,
    output fifo_status_t status
);

    result_t                     mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_WIDTH-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_WIDTH-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_LEVEL_WIDTH-1:0] level_reg, level_next;
    logic [FIFO_PTR_WIDTH-1:0]   wr_ptr_inc;

    always_comb begin
        wr_ptr_inc  = wr_ptr_reg + FIFO_PTR_WIDTH'(1);
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_WIDTH'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_PTR_WIDTH'(1) : rd_ptr_reg;
        level_next  = level_reg + FIFO_LEVEL_WIDTH'(push.count)
                      - FIFO_LEVEL_WIDTH'(pop);
        head          = mem_reg[rd_ptr_reg];
        status.level  = level_reg;
        status.room   = level_reg <= FIFO_LEVEL_WIDTH'(FIFO_DEPTH - 2);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_inc] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule
`default_nettype wire

### rtl/msb_first_bit_stream_concat.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msb_first_bit_stream_concat
// Joins two MSB-first packed bit strings into one packed byte stream.
// ----------------------------------------------------------------------------
// The block takes one source byte per cycle: first the bytes of the first
// string, then those of the second, as sized by the two length registers.
// Each byte passes through an input register and a single merge stage into a
// four-entry result queue, which registers each result before it is presented.
// The final byte of a job can yield two results; the queue absorbs them while
// input keeps flowing at one byte per cycle, as long as results are taken when
// presented. Input stalls only while more than two results wait in the queue.
// The last result of a job carries is_last, and the job
// counters then restart.
// Length registers are written through the configuration port, index 0 for
// the first length and 1 for the second; other indices are ignored.
// ----------------------------------------------------------------------------
module msb_first_bit_stream_concat import mbsc_pkg::*; #(
    parameter int LENGTH_WIDTH = 24
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    output wire logic                       cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [LENGTH_WIDTH-1:0]    cfg_wdata,
    input  wire logic                       s_valid,
    output wire logic                       s_ready,
    input  wire logic [7:0]                 s_data_byte,
    output wire logic                       m_valid,
    input  wire logic                       m_ready,
    output wire logic [7:0]                 m_out_byte,
    output wire logic                       m_is_last
);

    logic [LENGTH_WIDTH-1:0] first_len_reg, second_len_reg;
    logic [LENGTH_WIDTH-3:0] first_bytes_reg, second_bytes_reg;
    logic [LENGTH_WIDTH:0]   cfg_round;
    logic                    in_valid_reg;
    logic [7:0]              in_data_reg;
    logic                    step;
    push_t                   push;
    result_t                 head;
    fifo_status_t            fifo_status;

    assign cfg_ready  = 1'b1;
    assign cfg_round  = {1'b0, cfg_wdata} + (LENGTH_WIDTH + 1)'(7);
    assign step       = in_valid_reg && fifo_status.room;
    assign s_ready    = !in_valid_reg || step;
    assign m_valid    = fifo_status.level != '0;
    assign m_out_byte = head.out_byte;
    assign m_is_last  = head.is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_len_reg    <= '0;
            second_len_reg   <= '0;
            first_bytes_reg  <= '0;
            second_bytes_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FIRST_LENGTH: begin
                    first_len_reg   <= cfg_wdata;
                    first_bytes_reg <= cfg_round[LENGTH_WIDTH:3];
                end
                REG_SECOND_LENGTH: begin
                    second_len_reg   <= cfg_wdata;
                    second_bytes_reg <= cfg_round[LENGTH_WIDTH:3];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
        end
    end

    mbsc_core #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .data_byte    (in_data_reg),
        .first_len    (first_len_reg),
        .second_len   (second_len_reg),
        .first_bytes  (first_bytes_reg),
        .second_bytes (second_bytes_reg),
        .push         (push)
    );

    mbsc_out_fifo u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (m_valid && m_ready),
        .head    (head),
        .status  (fifo_status)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_status.level <= FIFO_LEVEL_WIDTH'(FIFO_DEPTH))
        else $error("Result queue has overflowed.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("An accepted transfer did not reach the input register.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !fifo_status.room) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("A held input byte was lost while the queue was full.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !fifo_status.room |-> (push.count == 2'd0))
        else $error("Results were produced without room in the queue.");

endmodule
`default_nettype wire
